FILE: rtl/core/ipv4_subnet_text_calculator_macros.svh
// Assertion macros used by the checker file of the subnet calculator.
`ifndef IPV4_SUBNET_TEXT_CALCULATOR_MACROS_SVH
`define IPV4_SUBNET_TEXT_CALCULATOR_MACROS_SVH

// Checked at every rising edge while the reset is released.
`define ISC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ISC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/isc_pkg.sv
// Package with the types, codes and helpers of the subnet calculator.
`timescale 1ns / 1ps

package isc_pkg;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_PREFIX,
        PH_SPACES,
        PH_MASK
    } t_phase;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_NOMASK   = 4'd1;
    localparam logic [3:0] ST_BADSEP   = 4'd2;
    localparam logic [3:0] ST_OCTET    = 4'd3;
    localparam logic [3:0] ST_DDOT     = 4'd4;
    localparam logic [3:0] ST_ILLEGAL  = 4'd5;
    localparam logic [3:0] ST_MANYDOTS = 4'd6;
    localparam logic [3:0] ST_BADMASK  = 4'd7;
    localparam logic [3:0] ST_PREFIX   = 4'd8;

    localparam logic [2:0] CLS_A = 3'd0;
    localparam logic [2:0] CLS_B = 3'd1;
    localparam logic [2:0] CLS_C = 3'd2;
    localparam logic [2:0] CLS_D = 3'd3;
    localparam logic [2:0] CLS_E = 3'd4;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [8:0] OCTET_MAX     = 9'd255;
    localparam logic [8:0] OCTET_CLAMP   = 9'd256;
    localparam logic [5:0] PREFIX_MAX    = 6'd32;
    localparam logic [5:0] PREFIX_CLAMP  = 6'd33;
    localparam logic [1:0] DOTS_FULL     = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] address;
        logic [31:0] net_mask;
        logic [5:0]  prefix_len;
    } t_line_rec;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/isc_stream_if.sv
// Valid/ready channels for the character items and the result items.
`timescale 1ns / 1ps

interface isc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface isc_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [5:0]  prefix_len;
    logic [31:0] network;
    logic [31:0] first_host;
    logic [31:0] last_host;
    logic [31:0] broadcast;
    logic [2:0]  address_class;
    logic [32:0] host_count;

    modport source (
        output valid, output status, output address, output net_mask,
        output prefix_len, output network, output first_host, output last_host,
        output broadcast, output address_class, output host_count, input ready
    );
    modport sink (
        input valid, input status, input address, input net_mask,
        input prefix_len, input network, input first_host, input last_host,
        input broadcast, input address_class, input host_count, output ready
    );
endinterface

FILE: rtl/core/isc_front.sv
// Character parser that assembles one line and classifies it at the newline.
`timescale 1ns / 1ps

module isc_front import isc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    isc_char_if.sink   i_char,
    input  logic       i_q_full,
    output logic       o_push,
    output t_line_rec  o_rec
);

    t_phase      r_phase, n_phase;
    logic [8:0]  r_octet, n_octet;
    logic [1:0]  r_dots, n_dots;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_mask, n_mask;
    logic [5:0]  r_prefix, n_prefix;
    logic [3:0]  r_err, n_err;
    logic        r_have, n_have;
    logic [4:0]  r_ones, n_ones;

    logic        w_accept;
    logic [7:0]  w_c;
    logic        w_digit;
    logic [3:0]  w_d;
    logic [11:0] w_oct_next;
    logic [8:0]  w_pre_next;
    logic        w_octet_done;
    logic [31:0] w_shift_oct;
    logic [31:0] w_dmask;
    logic [31:0] w_inv;
    logic [31:0] w_inv_inc;
    logic [3:0]  w_last_ones;

    assign i_char.ready = !i_q_full;
    assign w_accept     = i_char.valid && !i_q_full;
    assign w_c          = i_char.char_code;
    assign w_digit      = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_d          = 4'(w_c - CH_ZERO);
    assign w_oct_next   = 12'(r_octet) * 12'd10 + 12'(w_d);
    assign w_pre_next   = 9'(r_prefix) * 9'd10 + 9'(w_d);
    assign w_octet_done = (r_dots == DOTS_FULL) && r_have;
    assign w_shift_oct  = {24'd0, r_octet[7:0]};
    assign w_dmask      = {r_mask[23:0], r_octet[7:0]};
    assign w_inv        = ~w_dmask;
    assign w_inv_inc    = w_inv + 32'd1;
    assign w_last_ones  = popcount8(r_octet[7:0]);

    assign o_push = w_accept && (w_c == CH_NEWLINE);

    // Classification of the finished line.
    always_comb begin
        o_rec.status     = r_err;
        o_rec.address    = r_addr;
        o_rec.net_mask   = '0;
        o_rec.prefix_len = '0;
        if (r_err == ST_OK) begin
            case (r_phase)
                PH_ADDR: begin
                    o_rec.status = w_octet_done ? ST_NOMASK : ST_ILLEGAL;
                end
                PH_PREFIX: begin
                    if (!r_have) begin
                        o_rec.status = ST_ILLEGAL;
                    end else if (r_prefix > PREFIX_MAX) begin
                        o_rec.status = ST_PREFIX;
                    end else begin
                        o_rec.prefix_len = r_prefix;
                        o_rec.net_mask   = (r_prefix == '0) ? '0 :
                                           (32'hffffffff << (PREFIX_MAX - r_prefix));
                    end
                end
                PH_MASK: begin
                    if (!w_octet_done) begin
                        o_rec.status = ST_ILLEGAL;
                    end else if ((w_inv & w_inv_inc) != '0) begin
                        o_rec.status = ST_BADMASK;
                    end else begin
                        o_rec.net_mask   = w_dmask;
                        o_rec.prefix_len = 6'(r_ones) + 6'(w_last_ones);
                    end
                end
                default: begin
                    o_rec.status = ST_ILLEGAL;
                end
            endcase
        end
    end

    // Next state of the line parser.
    always_comb begin
        n_phase  = r_phase;
        n_octet  = r_octet;
        n_dots   = r_dots;
        n_addr   = r_addr;
        n_mask   = r_mask;
        n_prefix = r_prefix;
        n_err    = r_err;
        n_have   = r_have;
        n_ones   = r_ones;
        if (w_accept) begin
            if (w_c == CH_NEWLINE) begin
                n_phase  = PH_ADDR;
                n_octet  = '0;
                n_dots   = '0;
                n_addr   = '0;
                n_mask   = '0;
                n_prefix = '0;
                n_err    = ST_OK;
                n_have   = 1'b0;
                n_ones   = '0;
            end else if (r_err != ST_OK) begin
                n_err = r_err;
            end else if (w_digit) begin
                n_have = 1'b1;
                if (r_phase == PH_PREFIX) begin
                    n_prefix = (w_pre_next > 9'(PREFIX_MAX)) ? PREFIX_CLAMP
                                                               : w_pre_next[5:0];
                end else begin
                    if (r_phase == PH_SPACES) begin
                        n_phase = PH_MASK;
                    end
                    if (w_oct_next > 12'(OCTET_MAX)) begin
                        n_err   = ST_OCTET;
                        n_octet = OCTET_CLAMP;
                    end else begin
                        n_octet = w_oct_next[8:0];
                    end
                end
            end else if (w_c == CH_DOT) begin
                if (r_phase != PH_ADDR && r_phase != PH_MASK) begin
                    n_err = ST_ILLEGAL;
                end else if (!r_have) begin
                    n_err = (r_dots != '0) ? ST_DDOT : ST_ILLEGAL;
                end else if (r_dots == DOTS_FULL) begin
                    n_err = ST_MANYDOTS;
                end else begin
                    if (r_phase == PH_ADDR) begin
                        n_addr = (r_addr << 8) | w_shift_oct;
                    end else begin
                        n_mask = (r_mask << 8) | w_shift_oct;
                        n_ones = r_ones + 5'(w_last_ones);
                    end
                    n_dots  = r_dots + 2'd1;
                    n_octet = '0;
                    n_have  = 1'b0;
                end
            end else if (r_phase == PH_SPACES) begin
                if (w_c != CH_SPACE) begin
                    n_err = ST_ILLEGAL;
                end
            end else if (r_phase != PH_ADDR || !w_octet_done) begin
                n_err = ST_ILLEGAL;
            end else if (w_c == CH_SLASH || w_c == CH_SPACE) begin
                n_addr  = (r_addr << 8) | w_shift_oct;
                n_octet = '0;
                n_dots  = '0;
                n_have  = 1'b0;
                n_phase = (w_c == CH_SLASH) ? PH_PREFIX : PH_SPACES;
            end else begin
                n_err = ST_BADSEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ADDR;
            r_octet  <= '0;
            r_dots   <= '0;
            r_addr   <= '0;
            r_mask   <= '0;
            r_prefix <= '0;
            r_err    <= ST_OK;
            r_have   <= 1'b0;
            r_ones   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_octet  <= n_octet;
            r_dots   <= n_dots;
            r_addr   <= n_addr;
            r_mask   <= n_mask;
            r_prefix <= n_prefix;
            r_err    <= n_err;
            r_have   <= n_have;
            r_ones   <= n_ones;
        end
    end

endmodule

FILE: rtl/core/isc_queue.sv
// Short queue of classified lines between the parser and the result stage.
`timescale 1ns / 1ps

module isc_queue import isc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_line_rec  i_rec,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_line_rec  o_head
);

    t_line_rec            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_head    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

FILE: rtl/core/isc_back.sv
// Result stage that derives the subnet fields and holds the output item.
`timescale 1ns / 1ps

module isc_back import isc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_empty,
    input  t_line_rec    i_head,
    output logic         o_pop,
    isc_result_if.source o_result
);

    logic        r_valid, n_valid;
    logic [3:0]  r_status;
    logic [31:0] r_address;
    logic [31:0] r_net_mask;
    logic [5:0]  r_prefix_len;
    logic [31:0] r_network;
    logic [31:0] r_first_host;
    logic [31:0] r_last_host;
    logic [31:0] r_broadcast;
    logic [2:0]  r_address_class;
    logic [32:0] r_host_count;

    logic        w_load;
    logic        w_ok;
    logic [31:0] w_net;
    logic [31:0] w_bcast;
    logic [2:0]  w_class;

    assign w_load = !i_q_empty && (!r_valid || o_result.ready);
    assign o_pop  = w_load;
    assign w_ok   = (i_head.status == ST_OK);
    assign w_net  = i_head.address & i_head.net_mask;
    // The network and the inverted mask share no bit, so their sum is an OR.
    assign w_bcast = w_net | ~i_head.net_mask;

    always_comb begin
        if (!i_head.address[31]) begin
            w_class = CLS_A;
        end else if (!i_head.address[30]) begin
            w_class = CLS_B;
        end else if (!i_head.address[29]) begin
            w_class = CLS_C;
        end else if (!i_head.address[28]) begin
            w_class = CLS_D;
        end else begin
            w_class = CLS_E;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status        <= i_head.status;
            r_address       <= w_ok ? i_head.address : '0;
            r_net_mask      <= w_ok ? i_head.net_mask : '0;
            r_prefix_len    <= w_ok ? i_head.prefix_len : '0;
            r_network       <= w_ok ? w_net : '0;
            r_first_host    <= w_ok ? w_net + 32'd1 : '0;
            r_last_host     <= w_ok ? w_bcast - 32'd1 : '0;
            r_broadcast     <= w_ok ? w_bcast : '0;
            r_address_class <= w_ok ? w_class : '0;
            r_host_count    <= w_ok ? (33'd1 << (PREFIX_MAX - i_head.prefix_len)) : '0;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.status        = r_status;
    assign o_result.address       = r_address;
    assign o_result.net_mask      = r_net_mask;
    assign o_result.prefix_len    = r_prefix_len;
    assign o_result.network       = r_network;
    assign o_result.first_host    = r_first_host;
    assign o_result.last_host     = r_last_host;
    assign o_result.broadcast     = r_broadcast;
    assign o_result.address_class = r_address_class;
    assign o_result.host_count    = r_host_count;

endmodule

FILE: rtl/core/ipv4_subnet_text_calculator.sv
// Top level of the IPv4 subnet calculator that reads one text line per result.
// The block takes one ASCII character per cycle on i_char and, for every
// newline, returns one item on o_result with a status code and, when the line
// parsed cleanly, the address, mask, prefix length, network, first and last
// host, broadcast, class and host count. Characters stream back to back at one
// per cycle while the two-entry line queue between the parser and the result
// stage has room; when the queue is full, every character is held off until a
// line moves on. Results also leave at up to one per cycle. A result passes
// through two registers on its way to o_result: the line enters the queue at
// the edge that accepts its newline and moves on into the output register once
// it is at the head of the queue and the output register is free.
`timescale 1ns / 1ps

module ipv4_subnet_text_calculator import isc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isc_char_if.sink     i_char,
    isc_result_if.source o_result
);

    logic      w_push;
    logic      w_pop;
    logic      w_full;
    logic      w_empty;
    t_line_rec w_rec;
    t_line_rec w_head;

    isc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_rec    (w_rec)
    );

    isc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    isc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

endmodule

FILE: rtl/core/isc_checker.sv
// Port-level checks of the subnet calculator and their binding to the top level.
`timescale 1ns / 1ps
`include "ipv4_subnet_text_calculator_macros.svh"

module isc_checker import isc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_status,
    input logic [31:0] i_address,
    input logic [31:0] i_net_mask,
    input logic [31:0] i_network,
    input logic [31:0] i_broadcast,
    input logic [32:0] i_host_count
);

    `ISC_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !i_valid, "result item right after reset")

    `ISC_ASSERT(a_stalled_result_holds, i_clk, i_rst_n, i_valid && !i_ready |=> $stable(i_status) && $stable(i_address) && $stable(i_network), "stalled result item changed")

    `ISC_ASSERT(a_error_fields_zero, i_clk, i_rst_n, i_valid && i_status != ST_OK |-> i_address == '0 && i_net_mask == '0 && i_host_count == '0, "error item carries nonzero fields")

    `ISC_ASSERT(a_subnet_consistent, i_clk, i_rst_n, i_valid && i_status == ST_OK |-> i_network == (i_address & i_net_mask) && i_broadcast == (i_network | ~i_net_mask) && i_host_count != '0, "subnet fields disagree")

endmodule

bind ipv4_subnet_text_calculator isc_checker u_isc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_status     (o_result.status),
    .i_address    (o_result.address),
    .i_net_mask   (o_result.net_mask),
    .i_network    (o_result.network),
    .i_broadcast  (o_result.broadcast),
    .i_host_count (o_result.host_count)
);

FILE: tb/sv/ipv4_subnet_text_calculator_checker.sv
// Checker that parses the character items and compares every result item.
`timescale 1ns / 1ps

module ipv4_subnet_text_calculator_checker import isc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isc_char_if          i_char,
    isc_result_if        i_result,
    output int           o_fail_count,
    output int           o_outstanding
);

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] address;
        logic [31:0] net_mask;
        logic [5:0]  prefix_len;
        logic [31:0] network;
        logic [31:0] first_host;
        logic [31:0] last_host;
        logic [31:0] broadcast;
        logic [2:0]  address_class;
        logic [32:0] host_count;
    } t_subnet;

    t_subnet     expected_subnets[$];
    t_subnet     oldest;

    t_phase      cur_phase;
    logic [8:0]  cur_octet;
    logic [2:0]  dots_seen;
    logic [31:0] addr_bits;
    logic [31:0] mask_bits;
    logic [5:0]  prefix_val;
    logic [3:0]  first_err;
    logic        digit_seen;
    int          fails = 0;

    task automatic reset_parser();
        cur_phase  = PH_ADDR;
        cur_octet  = '0;
        dots_seen  = '0;
        addr_bits  = '0;
        mask_bits  = '0;
        prefix_val = '0;
        first_err  = ST_OK;
        digit_seen = 1'b0;
    endtask

    function automatic logic [31:0] shift_octet(input logic [31:0] acc);
        return {acc[23:0], cur_octet[7:0]};
    endfunction

    task automatic close_line();
        logic [3:0]  st;
        logic [31:0] m;
        logic [31:0] inv;
        logic [5:0]  plen;
        t_subnet     r;
        st   = first_err;
        m    = '0;
        plen = '0;
        r    = '0;
        if (st == ST_OK) begin
            case (cur_phase)
                PH_ADDR: begin
                    st = (dots_seen == DOTS_FULL && digit_seen) ? ST_NOMASK : ST_ILLEGAL;
                end
                PH_PREFIX: begin
                    if (!digit_seen) begin
                        st = ST_ILLEGAL;
                    end else if (prefix_val > PREFIX_MAX) begin
                        st = ST_PREFIX;
                    end else begin
                        plen = prefix_val;
                        m = (plen == 0) ? 32'h0 : (32'hffffffff << (32 - int'(plen)));
                    end
                end
                PH_MASK: begin
                    if (dots_seen != DOTS_FULL || !digit_seen) begin
                        st = ST_ILLEGAL;
                    end else begin
                        m   = shift_octet(mask_bits);
                        inv = ~m;
                        if ((inv & (inv + 32'd1)) != 32'd0) st = ST_BADMASK;
                        else plen = 6'(32 - $countones(inv));
                    end
                end
                default: begin
                    st = ST_ILLEGAL;
                end
            endcase
        end
        r.status = st;
        if (st == ST_OK) begin
            r.address    = addr_bits;
            r.net_mask   = m;
            r.prefix_len = plen;
            r.network    = addr_bits & m;
            r.first_host = r.network + 32'd1;
            r.last_host  = r.network + ~m - 32'd1;
            r.broadcast  = r.network + ~m;
            casez (addr_bits[31:28])
                4'b0???: r.address_class = CLS_A;
                4'b10??: r.address_class = CLS_B;
                4'b110?: r.address_class = CLS_C;
                4'b1110: r.address_class = CLS_D;
                default: r.address_class = CLS_E;
            endcase
            r.host_count = 33'd1 << (32 - int'(plen));
        end
        expected_subnets.push_back(r);
    endtask

    task automatic take_char(input logic [7:0] c);
        logic octet_done;
        int   d;
        int   v;
        if (c == CH_NEWLINE) begin
            close_line();
            reset_parser();
        end else if (first_err == ST_OK) begin
            octet_done = (dots_seen == DOTS_FULL && digit_seen);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = int'(c - CH_ZERO);
                if (cur_phase == PH_PREFIX) begin
                    v = int'(prefix_val) * 10 + d;
                    prefix_val = (v > int'(PREFIX_MAX)) ? PREFIX_CLAMP : 6'(v);
                end else begin
                    if (cur_phase == PH_SPACES) cur_phase = PH_MASK;
                    v = int'(cur_octet) * 10 + d;
                    if (v > int'(OCTET_MAX)) begin
                        first_err = ST_OCTET;
                        cur_octet = OCTET_CLAMP;
                    end else begin
                        cur_octet = 9'(v);
                    end
                end
                digit_seen = 1'b1;
            end else if (c == CH_DOT) begin
                if (cur_phase != PH_ADDR && cur_phase != PH_MASK) begin
                    first_err = ST_ILLEGAL;
                end else if (!digit_seen) begin
                    first_err = (dots_seen > 0) ? ST_DDOT : ST_ILLEGAL;
                end else if (dots_seen >= DOTS_FULL) begin
                    first_err = ST_MANYDOTS;
                end else begin
                    if (cur_phase == PH_ADDR) addr_bits = shift_octet(addr_bits);
                    else mask_bits = shift_octet(mask_bits);
                    dots_seen  = dots_seen + 3'd1;
                    cur_octet  = '0;
                    digit_seen = 1'b0;
                end
            end else if (cur_phase == PH_SPACES) begin
                if (c != CH_SPACE) first_err = ST_ILLEGAL;
            end else if (cur_phase != PH_ADDR || !octet_done) begin
                first_err = ST_ILLEGAL;
            end else if (c == CH_SLASH || c == CH_SPACE) begin
                addr_bits  = shift_octet(addr_bits);
                cur_octet  = '0;
                dots_seen  = '0;
                digit_seen = 1'b0;
                cur_phase  = (c == CH_SLASH) ? PH_PREFIX : PH_SPACES;
            end else begin
                first_err = ST_BADSEP;
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [32:0] want,
                               input logic [32:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            expected_subnets.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_subnets.size() == 0) begin
                    fails++;
                    $display("%0t ns: result item with status %0h, expected none",
                             $time, i_result.status);
                end else begin
                    oldest = expected_subnets.pop_front();
                    check_field("status", 33'(oldest.status), 33'(i_result.status));
                    check_field("address", 33'(oldest.address), 33'(i_result.address));
                    check_field("net_mask", 33'(oldest.net_mask), 33'(i_result.net_mask));
                    check_field("prefix_len", 33'(oldest.prefix_len),
                                33'(i_result.prefix_len));
                    check_field("network", 33'(oldest.network), 33'(i_result.network));
                    check_field("first_host", 33'(oldest.first_host),
                                33'(i_result.first_host));
                    check_field("last_host", 33'(oldest.last_host),
                                33'(i_result.last_host));
                    check_field("broadcast", 33'(oldest.broadcast),
                                33'(i_result.broadcast));
                    check_field("address_class", 33'(oldest.address_class),
                                33'(i_result.address_class));
                    check_field("host_count", oldest.host_count, i_result.host_count);
                end
            end
            if (i_char.valid && i_char.ready) take_char(i_char.char_code);
        end
        o_outstanding <= expected_subnets.size();
        o_fail_count  <= fails;
    end

endmodule

FILE: tb/sv/ipv4_subnet_text_calculator_tb.sv
// Testbench top that streams text lines into the subnet calculator and gives the verdict.
`timescale 1ns / 1ps

module ipv4_subnet_text_calculator_tb import isc_pkg::*;;

    localparam int LINE_CHARS_TARGET = 1450;
    localparam int QUIET_FROM        = 1230;
    localparam int HOLD_CYCLES       = 300;

    logic i_clk;
    logic i_rst_n;

    isc_char_if   char_bus ();
    isc_result_if result_bus ();

    int         fail_count;
    int         outstanding;
    logic [7:0] line_buf[$];
    int         sent_items = 0;
    bit         quiet = 1'b0;
    bit         calm = 1'b0;
    bit         stall_now = 1'b0;

    ipv4_subnet_text_calculator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .o_result (result_bus)
    );

    ipv4_subnet_text_calculator_checker u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char        (char_bus),
        .i_result      (result_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        result_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (stall_now) begin
                stall_now = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                result_bus.ready <= 1'b1;
            end else if (!quiet && !calm && $urandom_range(0, 6) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void add_num(input int unsigned v);
        if ($urandom_range(0, 19) == 0) line_buf.push_back(CH_ZERO);
        push_text($sformatf("%0d", v));
    endfunction

    function automatic void add_quad(input logic [31:0] v, input bit allow_big);
        for (int i = 0; i < 4; i++) begin
            if (i > 0) line_buf.push_back(CH_DOT);
            if (allow_big && $urandom_range(0, 39) == 0) add_num($urandom_range(256, 999));
            else add_num(v[31 - 8 * i -: 8]);
        end
    endfunction

    function automatic void mutate_line();
        int         pos;
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        pos  = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: line_buf[pos] = junk;
            1: line_buf.insert(pos, junk);
            default: line_buf.delete(pos);
        endcase
    endfunction

    function automatic void make_line();
        int          kind;
        int unsigned plen;
        logic [31:0] m;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 88) begin
            add_quad($urandom(), 1'b1);
            if ($urandom_range(0, 1) == 1) begin
                line_buf.push_back(CH_SLASH);
                if ($urandom_range(0, 9) == 0) add_num($urandom_range(33, 999));
                else add_num($urandom_range(0, 32));
            end else begin
                repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
                plen = $urandom_range(0, 32);
                m = (plen == 0) ? 32'h0 : (32'hffffffff << (32 - plen));
                if ($urandom_range(0, 7) == 0) m = $urandom();
                add_quad(m, 1'b0);
            end
            if (kind >= 76) repeat ($urandom_range(1, 2)) mutate_line();
        end else begin
            repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        line_buf.push_back(CH_NEWLINE);
    endfunction

    task automatic put_char(input logic [7:0] c);
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_line();
        calm = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i]) begin
            put_char(line_buf[i]);
            if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
                char_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        char_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    string directed_lines[] = '{
        "0.0.0.0/0\n",
        "255.255.255.255/32\n",
        "10.1.2.3 255.0.0.0\n",
        "128.9.8.7/16\n",
        "192.168.1.1   0.0.0.0\n",
        "224.0.0.1/4\n",
        "1.2.3.4 255.0.255.0\n",
        "1.2.3.4\n",
        "1.2.3.4x\n",
        "1.2.3.256/8\n",
        "1..2.3.4/8\n",
        ".1.2.3/8\n",
        "1.2.3.4.5\n",
        "1.2.3.4/33\n",
        "1.2.3/8\n",
        "1.2.3.4/\n",
        "1.2.3.4/8.\n",
        "1.2.3.4 255.255\n",
        "1.2.3.4 255.255.255.0 \n",
        "1.2.3.4  a\n",
        "\n",
        "007.2.3.4/99999\n"
    };

    initial begin
        int line_no;
        i_rst_n            <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_lines[i]) begin
            line_buf.delete();
            push_text(directed_lines[i]);
            send_line();
        end

        stall_now = 1'b1;
        line_no = 0;
        while (sent_items < LINE_CHARS_TARGET) begin
            quiet = (sent_items >= QUIET_FROM);
            if (line_no == 40) drain();
            make_line();
            send_line();
            line_no++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
